### rtl/nbody_gravity_accel_assert.svh
// assertion macros for the nbody_gravity_accel block
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef NBODY_GRAVITY_ACCEL_ASSERT_SVH
`define NBODY_GRAVITY_ACCEL_ASSERT_SVH
`ifndef SYNTHESIS
`define NBGA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NBGA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NBGA_ASSERT(lbl, clk, rst_n, prop, msg)
`define NBGA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### rtl/nbga_pkg.sv
// shared types and constants for the nbody_gravity_accel block
// no dependencies
package nbga_pkg;

  localparam int OPA_W     = 113;
  localparam int OPB_W     = 99;
  localparam int MUL_STEPS = 33;
  localparam int SQRT_STEPS = 33;
  localparam int QB_ACC    = 41;
  localparam int QB_EN     = 57;

  localparam logic [31:0] GRAV_RESET = 32'h0001_0000;
  localparam logic [40:0] ACC_CAP    = 41'h100_0000_0000;
  localparam logic [56:0] EN_CAP     = 57'h100_0000_0000_0000;

  typedef struct packed {
    logic [31:0] mass;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
  } body_t;

  typedef enum logic [2:0] {
    OP_MUL  = 3'b001,
    OP_SQRT = 3'b010,
    OP_DIV  = 3'b100
  } alu_op_t;

  typedef struct packed {
    logic             go;
    alu_op_t          op;
    logic             qlong;
    logic [OPA_W-1:0] a;
    logic [OPB_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic             done;
    logic             ovf;
    logic [OPB_W-1:0] res;
  } alu_rsp_t;

endpackage

### rtl/nbga_store.sv
// body memory: one entry per loaded body, synchronous read
// depends on nbga_pkg
module nbga_store import nbga_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  body_t                    wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output body_t                    rd_data
);

  body_t mem [DEPTH];
  body_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/nbga_alu.sv
// shared iterative unit: shift-add multiply, bit-pair square root, restoring divide
// depends on nbga_pkg and the assertion macro header
`include "nbody_gravity_accel_assert.svh"
module nbga_alu import nbga_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic        busy_r;
  logic        done_r;
  logic        chk_r;
  logic        ovf_r;
  alu_op_t     op_r;
  logic [5:0]  cnt_r;
  logic [99:0] acc_r;
  logic [98:0] sh_r;
  logic [98:0] den_r;
  logic [56:0] bq_r;

  logic [35:0] sq_rem;
  logic [35:0] sq_trial;
  logic        sq_ge;
  logic [99:0] dv_rem;
  logic        dv_ge;
  logic        chk_ge;
  logic [99:0] dv_init;
  logic        last_step;

  assign sq_rem    = {acc_r[33:0], sh_r[65:64]};
  assign sq_trial  = {bq_r[33:0], 2'b01};
  assign sq_ge     = sq_rem >= sq_trial;
  assign dv_rem    = {acc_r[98:0], sh_r[56]};
  assign dv_ge     = dv_rem >= {1'b0, den_r};
  assign chk_ge    = acc_r >= {1'b0, den_r};
  // upper part of the numerator forms the first partial remainder
  assign dv_init   = req.qlong ? 100'(req.a >> QB_EN) : 100'(req.a >> QB_ACC);
  assign last_step = cnt_r == 6'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (req.go) begin
          busy_r <= 1'b1;
        end
      end else if (op_r == OP_DIV && chk_r) begin
        // quotient would not fit: finish at once, caller caps
        if (chk_ge) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (last_step) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && req.go) begin
      op_r  <= req.op;
      ovf_r <= 1'b0;
      chk_r <= req.op == OP_DIV;
      unique case (req.op)
        OP_MUL: begin
          acc_r <= '0;
          sh_r  <= req.a[98:0];
          bq_r  <= 57'(req.b[32:0]);
          cnt_r <= 6'(MUL_STEPS);
        end
        OP_SQRT: begin
          acc_r <= '0;
          sh_r  <= req.a[98:0];
          bq_r  <= '0;
          cnt_r <= 6'(SQRT_STEPS);
        end
        OP_DIV: begin
          acc_r <= dv_init;
          sh_r  <= req.qlong ? 99'(req.a[56:0]) : 99'({req.a[40:0], 16'h0000});
          den_r <= req.b;
          bq_r  <= '0;
          cnt_r <= req.qlong ? 6'(QB_EN) : 6'(QB_ACC);
        end
        default: begin
          acc_r <= '0;
        end
      endcase
    end else if (busy_r) begin
      unique case (op_r)
        OP_MUL: begin
          if (bq_r[0]) begin
            acc_r <= acc_r + 100'(sh_r);
          end
          sh_r  <= sh_r << 1;
          bq_r  <= bq_r >> 1;
          cnt_r <= cnt_r - 6'd1;
        end
        OP_SQRT: begin
          if (sq_ge) begin
            acc_r <= 100'(sq_rem - sq_trial);
            bq_r  <= {bq_r[55:0], 1'b1};
          end else begin
            acc_r <= 100'(sq_rem);
            bq_r  <= {bq_r[55:0], 1'b0};
          end
          sh_r  <= sh_r << 2;
          cnt_r <= cnt_r - 6'd1;
        end
        OP_DIV: begin
          if (chk_r) begin
            chk_r <= 1'b0;
            ovf_r <= chk_ge;
          end else begin
            if (dv_ge) begin
              acc_r <= dv_rem - {1'b0, den_r};
              bq_r  <= {bq_r[55:0], 1'b1};
            end else begin
              acc_r <= dv_rem;
              bq_r  <= {bq_r[55:0], 1'b0};
            end
            sh_r  <= sh_r << 1;
            cnt_r <= cnt_r - 6'd1;
          end
        end
        default: begin
          cnt_r <= cnt_r;
        end
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.ovf  = ovf_r;
  assign rsp.res  = (op_r == OP_MUL) ? acc_r[98:0] : 99'(bq_r);

  `NBGA_ASSERT(a_go_when_free, clk, rst_n, req.go |-> !busy_r, "alu started while busy")
  `NBGA_ASSERT(a_done_single, clk, rst_n, done_r |=> !done_r, "alu done held two cycles")

endmodule

### rtl/nbody_gravity_accel.sv
// results: after the final body's transfer, one per loaded body, in load order;
//   a capped divide or a skipped coincident pair shortens the work for a body
// each pair term runs on the shared iterative unit (eight multiplies, one square root,
//   three divides); loading takes one cycle per body and busy holds off the next set
//   until the last result has gone out
// reset: synchronous active low, clears the body count, the sequencer and G to 1.0
// results are single-cycle strobes; the receiver cannot stall
`include "nbody_gravity_accel_assert.svh"
module nbody_gravity_accel import nbga_pkg::*; #(
  parameter int MAX_BODIES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        in_body_mass,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  input  logic               in_last_body,
  output logic               out_valid,
  output logic [5:0]         out_body_index,
  output logic signed [31:0] out_accel_x,
  output logic signed [31:0] out_accel_y,
  output logic signed [47:0] out_body_energy,
  output logic               out_coincident_flag,
  output logic               out_last_result,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data
);

  localparam int IW = $clog2(MAX_BODIES);
  localparam int CW = $clog2(MAX_BODIES + 1);

  typedef enum logic [19:0] {
    S_IDLE = 20'h00001,
    S_RD_I = 20'h00002,
    S_LD_I = 20'h00004,
    S_K_VX = 20'h00008,
    S_K_VY = 20'h00010,
    S_K_M  = 20'h00020,
    S_RD_J = 20'h00040,
    S_LD_J = 20'h00080,
    S_P_SX = 20'h00100,
    S_P_SY = 20'h00200,
    S_P_SQ = 20'h00400,
    S_P_GM = 20'h00800,
    S_P_R2 = 20'h01000,
    S_P_R3 = 20'h02000,
    S_P_NX = 20'h04000,
    S_P_QX = 20'h08000,
    S_P_NY = 20'h10000,
    S_P_QY = 20'h20000,
    S_P_NE = 20'h40000,
    S_P_QE = 20'h80000
  } state_t;

  function automatic logic [31:0] sat32(input logic [47:0] v);
    if (v[47:31] == {17{v[47]}}) begin
      return v[31:0];
    end
    return v[47] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  function automatic logic [47:0] sat48(input logic [63:0] v);
    if (v[63:47] == {17{v[63]}}) begin
      return v[47:0];
    end
    return v[63] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
  endfunction

  state_t      state_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] n_r;
  logic [CW-1:0] j_r;
  logic [IW-1:0] i_r;
  logic        issued_r;
  logic [31:0] grav_r;

  logic [31:0] mi_r;
  logic [31:0] pxi_r;
  logic [31:0] pyi_r;
  logic [31:0] vxm_r;
  logic [31:0] vym_r;
  logic [63:0] t1_r;
  logic [31:0] mj_r;
  logic [31:0] adx_r;
  logic [31:0] ady_r;
  logic        dxn_r;
  logic        dyn_r;
  logic [65:0] s_r;
  logic [32:0] r_r;
  logic [63:0] gm_r;
  logic [65:0] r2_r;
  logic [98:0] r3_r;
  logic [95:0] prod_r;
  logic [47:0] ax_r;
  logic [47:0] ay_r;
  logic [63:0] en_r;
  logic        coin_r;

  logic        out_valid_r;
  logic [5:0]  out_idx_r;
  logic [31:0] out_ax_r;
  logic [31:0] out_ay_r;
  logic [47:0] out_en_r;
  logic        out_coin_r;
  logic        out_last_r;

  body_t       wr_body;
  body_t       rd_body;
  logic        accept;
  logic        room;
  logic [IW-1:0] rd_addr;
  logic        last_i;

  logic [32:0] dx_w;
  logic [32:0] dy_w;
  logic [32:0] ndx_w;
  logic [32:0] ndy_w;
  logic [31:0] nvx_w;
  logic [31:0] nvy_w;

  alu_req_t    req;
  alu_rsp_t    rsp;
  logic        is_op;
  logic [40:0] acc_t;
  logic [56:0] en_t;
  logic [65:0] kin_w;
  logic [56:0] kin_t;

  assign accept  = start && !busy;
  assign room    = cnt_r < CW'(MAX_BODIES);
  assign last_i  = (CW'(i_r) + CW'(1)) == n_r;
  assign rd_addr = (state_r == S_RD_I) ? i_r : j_r[IW-1:0];

  assign wr_body.mass  = in_body_mass;
  assign wr_body.pos_x = in_pos_x;
  assign wr_body.pos_y = in_pos_y;
  assign wr_body.vel_x = in_vel_x;
  assign wr_body.vel_y = in_vel_y;

  nbga_store #(
    .DEPTH (MAX_BODIES)
  ) u_store (
    .clk     (clk),
    .wr_en   (accept && room),
    .wr_addr (cnt_r[IW-1:0]),
    .wr_data (wr_body),
    .rd_addr (rd_addr),
    .rd_data (rd_body)
  );

  nbga_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // separation from body i to body j, and magnitudes
  assign dx_w  = {rd_body.pos_x[31], rd_body.pos_x} - {pxi_r[31], pxi_r};
  assign dy_w  = {rd_body.pos_y[31], rd_body.pos_y} - {pyi_r[31], pyi_r};
  assign ndx_w = -dx_w;
  assign ndy_w = -dy_w;
  assign nvx_w = -rd_body.vel_x;
  assign nvy_w = -rd_body.vel_y;

  assign acc_t = (rsp.ovf || rsp.res[56:0] > 57'(ACC_CAP)) ? ACC_CAP : rsp.res[40:0];
  assign en_t  = (rsp.ovf || rsp.res[56:0] > EN_CAP) ? EN_CAP : rsp.res[56:0];
  assign kin_w = rsp.res[98:33];
  assign kin_t = (kin_w > 66'(EN_CAP)) ? EN_CAP : kin_w[56:0];

  always_comb begin
    req       = '0;
    req.op    = OP_MUL;
    req.qlong = 1'b0;
    is_op     = 1'b1;
    unique case (state_r)
      S_K_VX: begin
        req.a = OPA_W'(vxm_r);
        req.b = OPB_W'(vxm_r);
      end
      S_K_VY: begin
        req.a = OPA_W'(vym_r);
        req.b = OPB_W'(vym_r);
      end
      S_K_M: begin
        req.a = OPA_W'(t1_r);
        req.b = OPB_W'(mi_r);
      end
      S_P_SX: begin
        req.a = OPA_W'(adx_r);
        req.b = OPB_W'(adx_r);
      end
      S_P_SY: begin
        req.a = OPA_W'(ady_r);
        req.b = OPB_W'(ady_r);
      end
      S_P_SQ: begin
        req.op = OP_SQRT;
        req.a  = OPA_W'(s_r);
      end
      S_P_GM: begin
        req.a = OPA_W'(grav_r);
        req.b = OPB_W'(mj_r);
      end
      S_P_R2: begin
        req.a = OPA_W'(r_r);
        req.b = OPB_W'(r_r);
      end
      S_P_R3: begin
        req.a = OPA_W'(r2_r);
        req.b = OPB_W'(r_r);
      end
      S_P_NX: begin
        req.a = OPA_W'(gm_r);
        req.b = OPB_W'(adx_r);
      end
      S_P_NY: begin
        req.a = OPA_W'(gm_r);
        req.b = OPB_W'(ady_r);
      end
      S_P_QX, S_P_QY: begin
        req.op = OP_DIV;
        req.a  = OPA_W'({prod_r, 16'h0000});
        req.b  = r3_r;
      end
      S_P_NE: begin
        req.a = OPA_W'(gm_r);
        req.b = OPB_W'(mi_r);
      end
      S_P_QE: begin
        req.op    = OP_DIV;
        req.qlong = 1'b1;
        req.a     = OPA_W'(prod_r);
        req.b     = OPB_W'({r_r, 16'h0000});
      end
      default: begin
        is_op = 1'b0;
      end
    endcase
    req.go = is_op && !issued_r;
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
      grav_r      <= GRAV_RESET;
    end else begin
      out_valid_r <= (state_r == S_RD_J) && (j_r == n_r);
      if (cfg_wr_en) begin
        grav_r <= cfg_wr_data;
      end
      if (req.go) begin
        issued_r <= 1'b1;
      end else if (rsp.done) begin
        issued_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_last_body) begin
              cnt_r   <= '0;
              state_r <= S_RD_I;
            end else if (room) begin
              cnt_r <= cnt_r + CW'(1);
            end
          end
        end
        S_RD_I: state_r <= S_LD_I;
        S_LD_I: state_r <= S_K_VX;
        S_K_VX: if (rsp.done) state_r <= S_K_VY;
        S_K_VY: if (rsp.done) state_r <= S_K_M;
        S_K_M:  if (rsp.done) state_r <= S_RD_J;
        S_RD_J: begin
          if (j_r == n_r) begin
            state_r <= last_i ? S_IDLE : S_RD_I;
          end else if (j_r[IW-1:0] != i_r) begin
            state_r <= S_LD_J;
          end
        end
        S_LD_J: begin
          // coincident pair is skipped
          if (dx_w == '0 && dy_w == '0) begin
            state_r <= S_RD_J;
          end else begin
            state_r <= S_P_SX;
          end
        end
        S_P_SX: if (rsp.done) state_r <= S_P_SY;
        S_P_SY: if (rsp.done) state_r <= S_P_SQ;
        S_P_SQ: if (rsp.done) state_r <= S_P_GM;
        S_P_GM: if (rsp.done) state_r <= S_P_R2;
        S_P_R2: if (rsp.done) state_r <= S_P_R3;
        S_P_R3: if (rsp.done) state_r <= S_P_NX;
        S_P_NX: if (rsp.done) state_r <= S_P_QX;
        S_P_QX: if (rsp.done) state_r <= S_P_NY;
        S_P_NY: if (rsp.done) state_r <= S_P_QY;
        S_P_QY: if (rsp.done) state_r <= S_P_NE;
        S_P_NE: if (rsp.done) state_r <= S_P_QE;
        S_P_QE: if (rsp.done) state_r <= S_RD_J;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_last_body) begin
          n_r <= room ? cnt_r + CW'(1) : cnt_r;
          i_r <= '0;
        end
      end
      S_LD_I: begin
        mi_r   <= rd_body.mass;
        pxi_r  <= rd_body.pos_x;
        pyi_r  <= rd_body.pos_y;
        vxm_r  <= rd_body.vel_x[31] ? nvx_w : rd_body.vel_x;
        vym_r  <= rd_body.vel_y[31] ? nvy_w : rd_body.vel_y;
        ax_r   <= '0;
        ay_r   <= '0;
        coin_r <= 1'b0;
        j_r    <= '0;
      end
      S_K_VX: if (rsp.done) t1_r <= rsp.res[63:0];
      S_K_VY: if (rsp.done) t1_r <= t1_r + rsp.res[63:0];
      S_K_M:  if (rsp.done) en_r <= 64'(kin_t);
      S_RD_J: begin
        if (j_r == n_r) begin
          out_idx_r  <= 6'(i_r);
          out_ax_r   <= sat32(ax_r);
          out_ay_r   <= sat32(ay_r);
          out_en_r   <= sat48(en_r);
          out_coin_r <= coin_r;
          out_last_r <= last_i;
          if (!last_i) begin
            i_r <= i_r + IW'(1);
          end
        end else if (j_r[IW-1:0] == i_r) begin
          j_r <= j_r + CW'(1);
        end
      end
      S_LD_J: begin
        mj_r  <= rd_body.mass;
        dxn_r <= dx_w[32];
        dyn_r <= dy_w[32];
        adx_r <= dx_w[32] ? ndx_w[31:0] : dx_w[31:0];
        ady_r <= dy_w[32] ? ndy_w[31:0] : dy_w[31:0];
        if (dx_w == '0 && dy_w == '0) begin
          coin_r <= 1'b1;
          j_r    <= j_r + CW'(1);
        end
      end
      S_P_SX: if (rsp.done) s_r <= rsp.res[65:0];
      S_P_SY: if (rsp.done) s_r <= s_r + rsp.res[65:0];
      S_P_SQ: if (rsp.done) r_r <= rsp.res[32:0];
      S_P_GM: if (rsp.done) gm_r <= rsp.res[63:0];
      S_P_R2: if (rsp.done) r2_r <= rsp.res[65:0];
      S_P_R3: if (rsp.done) r3_r <= rsp.res;
      S_P_NX, S_P_NY, S_P_NE: if (rsp.done) prod_r <= rsp.res[95:0];
      S_P_QX: begin
        if (rsp.done) begin
          ax_r <= dxn_r ? ax_r - 48'(acc_t) : ax_r + 48'(acc_t);
        end
      end
      S_P_QY: begin
        if (rsp.done) begin
          ay_r <= dyn_r ? ay_r - 48'(acc_t) : ay_r + 48'(acc_t);
        end
      end
      S_P_QE: begin
        if (rsp.done) begin
          en_r <= en_r - 64'(en_t);
          j_r  <= j_r + CW'(1);
        end
      end
      default: begin
        coin_r <= coin_r;
      end
    endcase
  end

  assign busy                = state_r != S_IDLE;
  assign out_valid           = out_valid_r;
  assign out_body_index      = out_idx_r;
  assign out_accel_x         = out_ax_r;
  assign out_accel_y         = out_ay_r;
  assign out_body_energy     = out_en_r;
  assign out_coincident_flag = out_coin_r;
  assign out_last_result     = out_last_r;

  `NBGA_ASSERT(a_mid_result_busy, clk, rst_n, out_valid && !out_last_result |-> busy, "result mid-set while idle")
  `NBGA_ASSERT(a_result_spaced, clk, rst_n, out_valid |=> !out_valid, "results back to back")
  `NBGA_ASSERT(a_set_nonempty, clk, rst_n, busy |-> (n_r != '0), "computing an empty set")
  `NBGA_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !busy && !out_valid, "not idle after reset")

endmodule

### verif/tb_nbody_gravity_accel.sv
// testbench for nbody_gravity_accel: loads body sets, predicts per-body acceleration
// and energy in wide fixed point and checks every result strobe against the prediction,
// or typed-in values for fixed rows; depends on rtl/nbody_gravity_accel.sv and rtl/nbga_pkg.sv
`timescale 1ns / 1ps
module tb_nbody_gravity_accel;

  localparam int BODY_SLOTS = 16;
  localparam int RUN_ITEMS = 400;
  localparam int CYCLE_LIMIT = 20_000_000;
  localparam int SETTLE_CYCLES = 150;
  localparam int TAIL_CYCLES = 600;
  localparam longint unsigned ACCEL_CEIL = 64'd1 << 40;
  localparam longint unsigned ENERGY_CEIL = 64'd1 << 56;

  typedef enum logic {ROW_BODY, ROW_GRAV} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [31:0] mass;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] vx;
    logic [31:0] vy;
    logic        last;
    logic        fixed;
    logic [31:0] ax_fix;
    logic [31:0] ay_fix;
    logic [47:0] en_fix;
    logic        coin_fix;
  } stim_row_t;

  typedef struct {
    logic [5:0]  index;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [47:0] energy;
    logic        coin;
    logic        last;
  } body_result_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [31:0] in_body_mass;
  logic signed [31:0] in_pos_x;
  logic signed [31:0] in_pos_y;
  logic signed [31:0] in_vel_x;
  logic signed [31:0] in_vel_y;
  logic in_last_body;
  logic out_valid;
  logic [5:0] out_body_index;
  logic signed [31:0] out_accel_x;
  logic signed [31:0] out_accel_y;
  logic signed [47:0] out_body_energy;
  logic out_coincident_flag;
  logic out_last_result;
  logic cfg_wr_en;
  logic [31:0] cfg_wr_data;

  // typed-in expectation travelling alongside the driven body
  logic        drv_fixed;
  logic [31:0] drv_ax;
  logic [31:0] drv_ay;
  logic [47:0] drv_en;
  logic        drv_coin;

  nbody_gravity_accel #(.MAX_BODIES(BODY_SLOTS)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_body_mass(in_body_mass), .in_pos_x(in_pos_x), .in_pos_y(in_pos_y),
    .in_vel_x(in_vel_x), .in_vel_y(in_vel_y), .in_last_body(in_last_body),
    .out_valid(out_valid), .out_body_index(out_body_index),
    .out_accel_x(out_accel_x), .out_accel_y(out_accel_y),
    .out_body_energy(out_body_energy), .out_coincident_flag(out_coincident_flag),
    .out_last_result(out_last_result), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // predictor state
  logic [31:0] grav;
  logic [31:0] m_st[BODY_SLOTS];
  logic [31:0] px_st[BODY_SLOTS];
  logic [31:0] py_st[BODY_SLOTS];
  logic [31:0] vx_st[BODY_SLOTS];
  logic [31:0] vy_st[BODY_SLOTS];
  int unsigned n_loaded;

  body_result_t pending_results[$];
  int errors;
  int unsigned cycles;
  bit idle_on;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned floor_sqrt(logic [127:0] s);
    longint unsigned res;
    longint unsigned c;
    res = 0;
    for (int b = 33; b >= 0; b--) begin
      c = res | (64'd1 << b);
      if (128'(c) * 128'(c) <= s) res = c;
    end
    return res;
  endfunction

  function automatic longint unsigned div_capped(logic [127:0] num, logic [127:0] den,
                                                 longint unsigned ceil);
    logic [127:0] q;
    if (den == 0) return ceil;
    q = num / den;
    return (q > 128'(ceil)) ? ceil : q[63:0];
  endfunction

  // forces, energies and flags for every stored body, in load order
  function automatic void solve_set(bit fixed, logic [31:0] fax, logic [31:0] fay,
                                    logic [47:0] fen, logic fcoin);
    body_result_t r;
    longint ax, ay, en, dx, dy;
    longint unsigned vx, vy, kin, adx, ady, sep, gm, t;
    logic [127:0] k, s, r3, num;
    bit coin;
    for (int unsigned i = 0; i < n_loaded; i++) begin
      ax = 0;
      ay = 0;
      coin = 0;
      vx = magnitude(longint'($signed(vx_st[i])));
      vy = magnitude(longint'($signed(vy_st[i])));
      k = 128'(m_st[i]) * 128'(vx * vx + vy * vy);
      kin = 64'(k >> 33);
      en = longint'((kin > ENERGY_CEIL) ? ENERGY_CEIL : kin);
      for (int unsigned j = 0; j < n_loaded; j++) begin
        if (j == i) continue;
        dx = longint'($signed(px_st[j])) - longint'($signed(px_st[i]));
        dy = longint'($signed(py_st[j])) - longint'($signed(py_st[i]));
        if (dx == 0 && dy == 0) begin
          coin = 1;
          continue;
        end
        adx = magnitude(dx);
        ady = magnitude(dy);
        s = 128'(adx) * 128'(adx) + 128'(ady) * 128'(ady);
        sep = floor_sqrt(s);
        gm = 64'(grav) * 64'(m_st[j]);
        r3 = 128'(sep) * 128'(sep) * 128'(sep);
        num = (128'(gm) * 128'(adx)) << 16;
        t = div_capped(num, r3, ACCEL_CEIL);
        ax += (dx < 0) ? -longint'(t) : longint'(t);
        num = (128'(gm) * 128'(ady)) << 16;
        t = div_capped(num, r3, ACCEL_CEIL);
        ay += (dy < 0) ? -longint'(t) : longint'(t);
        t = div_capped(128'(gm) * 128'(m_st[i]), 128'(sep) << 16, ENERGY_CEIL);
        en -= longint'(t);
      end
      if (ax > 64'sd2147483647) ax = 64'sd2147483647;
      if (ax < -64'sd2147483648) ax = -64'sd2147483648;
      if (ay > 64'sd2147483647) ay = 64'sd2147483647;
      if (ay < -64'sd2147483648) ay = -64'sd2147483648;
      if (en > 64'sd140737488355327) en = 64'sd140737488355327;
      if (en < -64'sd140737488355328) en = -64'sd140737488355328;
      r.index = i[5:0];
      r.ax = fixed ? fax : ax[31:0];
      r.ay = fixed ? fay : ay[31:0];
      r.energy = fixed ? fen : en[47:0];
      r.coin = fixed ? fcoin : coin;
      r.last = (i + 1 == n_loaded);
      pending_results.insert(pending_results.size(), r);
    end
  endfunction

  // predictor follows every transfer and register write
  always @(posedge clk) begin
    if (!rst_n) begin
      grav <= 32'h0001_0000;
      n_loaded = 0;
    end else begin
      if (cfg_wr_en) grav <= cfg_wr_data;
      if (start && !busy) begin
        if (n_loaded < BODY_SLOTS) begin
          m_st[n_loaded] = in_body_mass;
          px_st[n_loaded] = in_pos_x;
          py_st[n_loaded] = in_pos_y;
          vx_st[n_loaded] = in_vel_x;
          vy_st[n_loaded] = in_vel_y;
          n_loaded++;
        end
        if (in_last_body) begin
          solve_set(drv_fixed, drv_ax, drv_ay, drv_en, drv_coin);
          n_loaded = 0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    body_result_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result for body %0d with nothing outstanding", out_body_index);
        errors++;
      end else begin
        e = pending_results.pop_front();
        check_field("body_index", 64'(e.index), 64'(out_body_index));
        check_field("accel_x", 64'(e.ax), 64'($unsigned(out_accel_x)));
        check_field("accel_y", 64'(e.ay), 64'($unsigned(out_accel_y)));
        check_field("body_energy", 64'(e.energy), 64'($unsigned(out_body_energy)));
        check_field("coincident_flag", 64'(e.coin), 64'(out_coincident_flag));
        check_field("last_result", 64'(e.last), 64'(out_last_result));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic idle_gap();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 11)) begin
        @(negedge clk);
        start = 1'b0;
      end
    end
  endtask

  task automatic send_body(stim_row_t row);
    idle_gap();
    @(negedge clk);
    in_body_mass = row.mass;
    in_pos_x = row.px;
    in_pos_y = row.py;
    in_vel_x = row.vx;
    in_vel_y = row.vy;
    in_last_body = row.last;
    drv_fixed = row.fixed;
    drv_ax = row.ax_fix;
    drv_ay = row.ay_fix;
    drv_en = row.en_fix;
    drv_coin = row.coin_fix;
    start = 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic write_gravity(logic [31:0] value);
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  function automatic stim_row_t body_row(logic [31:0] m, logic [31:0] px, logic [31:0] py,
                                         logic [31:0] vx, logic [31:0] vy, logic last);
    stim_row_t row;
    row = '{kind: ROW_BODY, mass: m, px: px, py: py, vx: vx, vy: vy, last: last,
            fixed: 1'b0, ax_fix: '0, ay_fix: '0, en_fix: '0, coin_fix: 1'b0};
    return row;
  endfunction

  function automatic stim_row_t fixed_row(stim_row_t row, logic [31:0] ax, logic [31:0] ay,
                                          logic [47:0] en, logic coin);
    row.fixed = 1'b1;
    row.ax_fix = ax;
    row.ay_fix = ay;
    row.en_fix = en;
    row.coin_fix = coin;
    return row;
  endfunction

  function automatic stim_row_t grav_row(logic [31:0] value);
    stim_row_t row;
    row = body_row(value, '0, '0, '0, '0, 1'b0);
    row.kind = ROW_GRAV;
    return row;
  endfunction

  function automatic logic [31:0] rand_coord();
    // half the time a tight cluster so forces stay in range, otherwise anywhere
    if ($urandom_range(0, 1)) return 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
    return $urandom;
  endfunction

  function automatic logic [31:0] rand_mass();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0000_ffff);
      default: return $urandom_range(0, 32'h0040_0000);
    endcase
  endfunction

  function automatic logic [31:0] rand_vel();
    if ($urandom_range(0, 4) < 3) return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
    return $urandom;
  endfunction

  stim_row_t directed[$];
  stim_row_t row;
  logic [31:0] last_px, last_py;
  int sent, set_no, n_set;

  function automatic void queue_row(stim_row_t r);
    directed.insert(directed.size(), r);
  endfunction

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_body_mass = '0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_vel_x = '0;
    in_vel_y = '0;
    in_last_body = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    drv_fixed = 1'b0;
    drv_ax = '0;
    drv_ay = '0;
    drv_en = '0;
    drv_coin = 1'b0;
    errors = 0;
    cycles = 0;
    idle_on = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // lone massless body at rest, then lone heaviest body at top speed (energy saturates)
    queue_row(fixed_row(body_row('0, '0, '0, '0, '0, 1), '0, '0, '0, 0));
    queue_row(fixed_row(body_row(32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 1), '0, '0, 48'h7fff_ffff_ffff, 0));
    // coincident pair at rest
    queue_row(body_row(32'h0001_0000, 32'h0005_0000, 32'h0005_0000, '0, '0, 0));
    queue_row(fixed_row(body_row(32'h0002_0000, 32'h0005_0000, 32'h0005_0000,
              '0, '0, 1), '0, '0, '0, 1));
    queue_row(body_row(32'h0001_0000, '0, '0, 32'h0000_8000, 32'hffff_c000, 0));
    queue_row(body_row(32'h0001_0000, 32'h0001_0000, '0, '0, '0, 1));
    // opposite corners of the coordinate range
    queue_row(body_row(32'hffff_ffff, 32'h8000_0000, 32'h8000_0000,
              32'h7fff_ffff, 32'h7fff_ffff, 0));
    queue_row(body_row(32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
              32'h8000_0000, 32'h7fff_ffff, 1));
    // heavy pair one lsb apart: accelerations and potential saturate
    queue_row(body_row(32'hffff_ffff, '0, '0, '0, '0, 0));
    queue_row(body_row(32'hffff_ffff, 32'h0000_0001, '0, '0, '0, 1));
    // no gravity: kinetic energy only
    queue_row(grav_row('0));
    queue_row(body_row(32'h0001_0000, '0, '0, 32'h0001_0000, 32'hffff_0000, 0));
    queue_row(fixed_row(body_row(32'h0001_0000, 32'h0002_0000, 32'hfffd_0000,
              32'hffff_0000, 32'h0001_0000, 1), '0, '0, 48'h0000_0001_0000, 0));
    queue_row(grav_row(32'hffff_ffff));
    queue_row(body_row(32'h0003_0000, '0, '0, '0, '0, 0));
    queue_row(body_row(32'h0001_0000, 32'hfffc_0000, 32'h0003_0000,
              32'hfffe_0000, 32'h0000_8000, 0));
    queue_row(body_row(32'h0000_8000, 32'h0003_0000, 32'hfffc_0000, '0, '0, 1));
    queue_row(grav_row(32'h0001_0000));

    sent = 0;
    foreach (directed[i]) begin
      if (directed[i].kind == ROW_GRAV) write_gravity(directed[i].mass);
      else begin
        send_body(directed[i]);
        sent++;
      end
    end

    set_no = 0;
    last_px = '0;
    last_py = '0;
    while (sent < RUN_ITEMS) begin
      if (set_no % 25 == 24) begin
        case ($urandom_range(0, 4))
          0: write_gravity('0);
          1: write_gravity(32'hffff_ffff);
          2: write_gravity($urandom);
          default: write_gravity($urandom_range(1, 32'h0004_0000));
        endcase
      end
      // full store once exactly, and once with the closing body dropped
      if (set_no == 30) n_set = BODY_SLOTS;
      else if (set_no == 70) n_set = BODY_SLOTS + 1;
      else if ($urandom_range(0, 9) == 0) n_set = $urandom_range(5, 7);
      else n_set = $urandom_range(1, 4);
      if (sent > RUN_ITEMS * 4 / 5) idle_on = 1'b0;
      for (int b = 0; b < n_set; b++) begin
        row = body_row(rand_mass(), rand_coord(), rand_coord(), rand_vel(), rand_vel(),
                       b == n_set - 1);
        if (b > 0 && $urandom_range(0, 9) == 0) begin
          row.px = last_px;
          row.py = last_py;
        end
        last_px = row.px;
        last_py = row.py;
        send_body(row);
        sent++;
      end
      set_no++;
    end

    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/nbga_pkg.sv
rtl/nbga_store.sv
rtl/nbga_alu.sv
rtl/nbody_gravity_accel.sv
verif/tb_nbody_gravity_accel.sv
